### design/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg
// Shared types and codes for the generational handle slot table.
// ----------------------------------------------------------------------------
package ghst_pkg;

	localparam int HANDLE_W = 64;

	// operation codes carried in the kind field
	localparam logic [1:0] KIND_RESERVE = 2'd0;
	localparam logic [1:0] KIND_CHECK   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SLOT    = 2'd1,
		ST_BAD_HANDLE = 2'd2
	} status_t;

endpackage

### design/generational_handle_slot_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_table_top
// Path: an accepted item passes the input register and then the result register.
// Throughput: one item per cycle while out_ready does not stall the result register;
// the table updates as an item leaves the input register, so the next item sees the
// new state.
// Reset: all generations zero, no slot in use, every slot reusable.
// ----------------------------------------------------------------------------
module generational_handle_slot_table_top #(
	parameter int SLOT_COUNT      = 4,
	parameter int SLOT_FIELD_BITS = 3,
	parameter int GENERATION_BITS = 61
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [ghst_pkg::HANDLE_W-1:0] handle_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [1:0]                    slot_number,
	output logic [ghst_pkg::HANDLE_W-1:0] handle_out
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [GENERATION_BITS-1:0] GEN_MAX = '1;

	// table state
	logic [GENERATION_BITS-1:0] gen_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]      busy_q;
	logic [SLOT_COUNT-1:0]      reusable_q;

	// input stage
	logic                          valid_s1;
	logic [1:0]                    kind_s1;
	logic [ghst_pkg::HANDLE_W-1:0] handle_s1;

	// result stage
	logic                          valid_s2;
	ghst_pkg::status_t             status_s2;
	logic [1:0]                    slot_s2;
	logic [ghst_pkg::HANDLE_W-1:0] handle_s2;

	logic                       adv_s2;
	logic                       adv_s1;
	logic [SLOT_COUNT-1:0]      retired;
	logic [SLOT_COUNT-1:0]      hit;
	logic [SLOT_COUNT-1:0]      pick;
	logic [SLOT_COUNT-1:0]      keep;
	logic [IDX_W-1:0]           hit_idx;
	logic [IDX_W-1:0]           pick_idx;
	logic [GENERATION_BITS-1:0] gen_sel;
	logic [GENERATION_BITS-1:0] gen_next;
	logic                       do_reserve;
	logic                       do_release;
	ghst_pkg::status_t          status_d;
	logic [IDX_W-1:0]           idx_d;
	logic [ghst_pkg::HANDLE_W-1:0] handle_d;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			retired[i] = gen_q[i] == GEN_MAX;
		end
	end

	ghst_lookup #(
		.SLOT_COUNT     (SLOT_COUNT),
		.SLOT_FIELD_BITS(SLOT_FIELD_BITS),
		.GENERATION_BITS(GENERATION_BITS)
	) u_lookup (
		.handle(handle_s1),
		.gen   (gen_q),
		.busy  (busy_q),
		.hit   (hit)
	);

	ghst_pick #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_pick (
		.reusable(reusable_q),
		.retired (retired),
		.pick    (pick),
		.keep    (keep)
	);

	always_comb begin
		hit_idx  = '0;
		pick_idx = '0;
		gen_sel  = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (pick[i]) begin
				pick_idx = pick_idx | IDX_W'(i);
				gen_sel  = gen_sel | gen_q[i];
			end
		end
	end

	assign gen_next = gen_sel + GENERATION_BITS'(1);

	always_comb begin
		status_d   = ghst_pkg::ST_BAD_HANDLE;
		idx_d      = '0;
		handle_d   = '0;
		do_reserve = 1'b0;
		do_release = 1'b0;
		case (kind_s1)
			ghst_pkg::KIND_RESERVE: begin
				do_reserve = 1'b1;
				if (|pick) begin
					status_d = ghst_pkg::ST_OK;
					idx_d    = pick_idx;
					handle_d = (ghst_pkg::HANDLE_W'(gen_next) << SLOT_FIELD_BITS)
						| (ghst_pkg::HANDLE_W'(pick_idx) + ghst_pkg::HANDLE_W'(1));
				end else begin
					status_d = ghst_pkg::ST_NO_SLOT;
				end
			end
			ghst_pkg::KIND_CHECK, ghst_pkg::KIND_RELEASE: begin
				do_release = kind_s1 == ghst_pkg::KIND_RELEASE;
				if (|hit) begin
					status_d = ghst_pkg::ST_OK;
					idx_d    = hit_idx;
				end
			end
			default: begin
				status_d = ghst_pkg::ST_BAD_HANDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1   <= kind;
			handle_s1 <= handle_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_d;
			slot_s2   <= 2'(idx_d);
			handle_s2 <= handle_d;
		end
	end

	// table update as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			reusable_q <= '1;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				gen_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (do_reserve) begin
				reusable_q <= reusable_q & keep;
				busy_q     <= busy_q | pick;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (pick[i]) begin
						gen_q[i] <= gen_next;
					end
				end
			end else if (do_release) begin
				busy_q     <= busy_q & ~hit;
				reusable_q <= reusable_q | (hit & ~retired);
			end
		end
	end

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign slot_number = slot_s2;
	assign handle_out  = handle_s2;

	// a slot is never both in use and up for reuse
	a_busy_not_reusable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q & reusable_q) == '0)
		else $error("slot busy and reusable at once");

	// an exhausted slot is never offered again
	a_retired_not_reusable: assert property (@(posedge clk) disable iff (!arst_n)
		(retired & reusable_q) == '0)
		else $error("retired slot marked reusable");

	// a handle names at most one slot
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(hit))
		else $error("handle matched several slots");

	// a failed item carries no slot and no handle
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != ghst_pkg::ST_OK) |-> (slot_s2 == '0 && handle_s2 == '0))
		else $error("failed item with nonzero payload");

	// a reserve that succeeds marks its slot busy
	a_reserve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && do_reserve && (|pick)) |=> ((busy_q & $past(pick)) == $past(pick)))
		else $error("reserved slot not busy");

endmodule

### design/ghst_lookup.sv
// ----------------------------------------------------------------------------
// ghst_lookup
// Decodes a handle and flags the slot it names when the reservation is live.
// ----------------------------------------------------------------------------
module ghst_lookup #(
	parameter int SLOT_COUNT      = 4,
	parameter int SLOT_FIELD_BITS = 3,
	parameter int GENERATION_BITS = 61
) (
	input  logic [ghst_pkg::HANDLE_W-1:0] handle,
	input  logic [GENERATION_BITS-1:0]    gen [SLOT_COUNT],
	input  logic [SLOT_COUNT-1:0]         busy,
	output logic [SLOT_COUNT-1:0]         hit
);

	logic [SLOT_FIELD_BITS-1:0]    field;
	logic [ghst_pkg::HANDLE_W-1:0] gen_field;
	logic                          gen_in_range;
	logic                          basic_ok;

	assign field        = handle[SLOT_FIELD_BITS-1:0];
	assign gen_field    = handle >> SLOT_FIELD_BITS;
	// generation must fit in GENERATION_BITS
	assign gen_in_range = (gen_field >> GENERATION_BITS) == '0;
	assign basic_ok     = (handle != '0) && (handle != '1) && (gen_field != '0)
		&& gen_in_range;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			hit[i] = basic_ok
				&& ({{(32-SLOT_FIELD_BITS){1'b0}}, field} == 32'(i + 1))
				&& (ghst_pkg::HANDLE_W'(gen[i]) == gen_field)
				&& busy[i];
		end
	end

endmodule

### design/ghst_pick.sv
// ----------------------------------------------------------------------------
// ghst_pick
// Priority pick of the lowest reusable, non-retired slot for a reserve.
// ----------------------------------------------------------------------------
module ghst_pick #(
	parameter int SLOT_COUNT = 4
) (
	input  logic [SLOT_COUNT-1:0] reusable,
	input  logic [SLOT_COUNT-1:0] retired,
	output logic [SLOT_COUNT-1:0] pick,
	output logic [SLOT_COUNT-1:0] keep
);

	logic seen;

	// every reusable bit up to and including the pick is cleared
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			keep[i] = seen;
			pick[i] = reusable[i] && !retired[i] && !seen;
			seen    = seen | pick[i];
		end
	end

endmodule
